// ----- hw/rtl/char_lcd_nibble_sequencer_unit_defines.svh -----
// Assertion macros used by the character LCD nibble sequencer controller.
// Depends on a clock named clk and a synchronous reset named rst in scope.
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_UNIT_DEFINES_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// Check a property outside of reset.
`define LCDSEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every edge, reset included.
`define LCDSEQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LCDSEQ_ASSERT(lbl, prop, msg)
`define LCDSEQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- hw/rtl/lcdseq_pkg.sv -----
// Shared types and constants for the character LCD nibble sequencer.
// No dependencies; imported by the controller, datapath and top level.
package lcdseq_pkg;

  // Field widths
  localparam int HOLD_W      = 16;
  localparam int PHASE_W     = 13;
  localparam int SETTLE_W    = 13;
  localparam int WAKE_W      = 16;
  localparam int PWR_W       = 16;
  localparam int CMD_W       = 8;
  localparam int NIB_W       = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int NIB_IDX_W   = 4;

  // Register reset values
  localparam logic [PHASE_W-1:0]  PHASE_HOLD_RST   = 13'd200;
  localparam logic [WAKE_W-1:0]   WAKE_WAIT_RST    = 16'd5000;
  localparam logic [SETTLE_W-1:0] SETTLE_WAIT_RST  = 13'd200;
  localparam logic [PWR_W-1:0]    POWER_UP_RST     = 16'd15000;
  localparam logic [CMD_W-1:0]    FUNC_SET_RST     = 8'h28;
  localparam logic [CMD_W-1:0]    DISP_CTRL_RST    = 8'h0C;

  // Fixed init bytes and nibbles
  localparam logic [NIB_W-1:0] WAKE_NIB    = 4'h3;
  localparam logic [NIB_W-1:0] FOURBIT_NIB = 4'h2;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 8'h01;
  localparam logic [CMD_W-1:0] CMD_ENTRY   = 8'h06;

  // Nibble slots: a write has two, init has four wake nibbles plus four bytes
  localparam logic [NIB_IDX_W-1:0] NIB_LAST_WRITE = 4'd1;
  localparam logic [NIB_IDX_W-1:0] NIB_LAST_INIT  = 4'd11;
  localparam logic [NIB_IDX_W-1:0] NIB_FIRST_CMD  = 4'd4;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_HOLD  = 3'd0,
    CFG_WAKE_WAIT   = 3'd1,
    CFG_SETTLE_WAIT = 3'd2,
    CFG_POWER_UP    = 3'd3,
    CFG_FUNC_SET    = 3'd4,
    CFG_DISP_CTRL   = 3'd5
  } lcdseq_cfg_idx_t;

  // Phases of one nibble
  typedef enum logic [1:0] {
    PH_SETUP   = 2'd0,
    PH_EN_HIGH = 2'd1,
    PH_EN_LOW  = 2'd2
  } lcdseq_phase_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_PWR  = 2'd1,
    ST_NIB  = 2'd2
  } lcdseq_state_t;

  // Controller to datapath
  typedef struct packed {
    logic                 load_item;
    logic                 emit;
    logic                 power;
    logic                 init;
    logic [NIB_IDX_W-1:0] nib_idx;
    lcdseq_phase_t        phase;
    logic                 last;
  } lcdseq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic slot_free;
  } lcdseq_sts_t;

endpackage

// ----- hw/rtl/lcdseq_ctrl.sv -----
// Phase sequencer state machine of the character LCD nibble sequencer.
// Depends on lcdseq_pkg and the assertion macros header.
`include "char_lcd_nibble_sequencer_unit_defines.svh"
module lcdseq_ctrl
  import lcdseq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  lcdseq_sts_t sts,
  output lcdseq_cmd_t cmd
);

  lcdseq_state_t        state, state_next;
  logic [NIB_IDX_W-1:0] nib_idx, nib_idx_next;
  lcdseq_phase_t        phase, phase_next;
  logic                 init_mode, init_mode_next;
  logic                 accept;
  logic                 is_last;

  assign accept = in_valid && in_ready;
  assign is_last = (state == ST_NIB) && (phase == PH_EN_LOW) &&
                   (nib_idx == (init_mode ? NIB_LAST_INIT : NIB_LAST_WRITE));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = mode ? ST_NIB : ST_PWR;
      end
      ST_PWR: begin
        if (sts.slot_free) state_next = ST_NIB;
      end
      ST_NIB: begin
        if (sts.slot_free && is_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Advance the nibble and phase counters
  always_comb begin
    nib_idx_next   = nib_idx;
    phase_next     = phase;
    init_mode_next = init_mode;
    if (accept) begin
      nib_idx_next   = '0;
      phase_next     = PH_SETUP;
      init_mode_next = !mode;
    end else if (state == ST_NIB && sts.slot_free && !is_last) begin
      case (phase)
        PH_SETUP:   phase_next = PH_EN_HIGH;
        PH_EN_HIGH: phase_next = PH_EN_LOW;
        PH_EN_LOW: begin
          phase_next   = PH_SETUP;
          nib_idx_next = nib_idx + 1'b1;
        end
        default:    phase_next = PH_SETUP;
      endcase
    end
  end

  // Outputs
  always_comb begin
    in_ready      = (state == ST_IDLE);
    cmd.load_item = accept;
    cmd.emit      = 1'b0;
    cmd.power     = (state == ST_PWR);
    cmd.init      = init_mode;
    cmd.nib_idx   = nib_idx;
    cmd.phase     = phase;
    cmd.last      = is_last;
    case (state)
      ST_IDLE: cmd.emit = 1'b0;
      ST_PWR:  cmd.emit = sts.slot_free;
      ST_NIB:  cmd.emit = sts.slot_free;
      default: cmd.emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      nib_idx   <= '0;
      phase     <= PH_SETUP;
      init_mode <= 1'b0;
    end else begin
      state     <= state_next;
      nib_idx   <= nib_idx_next;
      phase     <= phase_next;
      init_mode <= init_mode_next;
    end
  end

  `LCDSEQ_ASSERT_ALWAYS(a_rst_idle, rst |=> state == ST_IDLE, "not idle after reset")
  `LCDSEQ_ASSERT(a_emit_free, cmd.emit |-> sts.slot_free, "phase issued into full slot")
  `LCDSEQ_ASSERT(a_last_low, cmd.last |-> cmd.phase == PH_EN_LOW, "last not on enable low")
  `LCDSEQ_ASSERT(a_write_idx, (state == ST_NIB && !init_mode) |-> nib_idx <= NIB_LAST_WRITE,
                 "write item ran past its low nibble")
  `LCDSEQ_ASSERT(a_done_idle, (cmd.emit && cmd.last) |=> state == ST_IDLE,
                 "no return to idle after last phase")

endmodule

// ----- hw/rtl/lcdseq_dp.sv -----
// Datapath of the character LCD nibble sequencer: config registers,
// item latch, nibble and hold selection, output register. Uses lcdseq_pkg.
module lcdseq_dp
  import lcdseq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [CMD_W-1:0]      byte_value,
  input  logic                  register_select,
  input  lcdseq_cmd_t           cmd,
  output lcdseq_sts_t           sts,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  rs_pin,
  output logic                  rw_pin,
  output logic [NIB_W-1:0]      data_nibble,
  output logic                  enable_pin,
  output logic [HOLD_W-1:0]     hold_us,
  output logic                  last_phase
);

  logic [PHASE_W-1:0]  phase_hold_us;
  logic [WAKE_W-1:0]   wake_wait_us;
  logic [SETTLE_W-1:0] settle_wait_us;
  logic [PWR_W-1:0]    power_up_wait_us;
  logic [CMD_W-1:0]    function_set_cmd;
  logic [CMD_W-1:0]    display_ctrl_cmd;
  logic [NIB_W-1:0]    driven_nibble;
  logic [CMD_W-1:0]    item_byte;
  logic                item_rs;

  logic [CMD_W-1:0]    init_byte;
  logic [NIB_W-1:0]    sel_nib;
  logic [WAKE_W-1:0]   extra;
  logic [HOLD_W:0]     hold_sum;
  logic [HOLD_W-1:0]   hold_sel;

  // Configuration writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_hold_us    <= PHASE_HOLD_RST;
      wake_wait_us     <= WAKE_WAIT_RST;
      settle_wait_us   <= SETTLE_WAIT_RST;
      power_up_wait_us <= POWER_UP_RST;
      function_set_cmd <= FUNC_SET_RST;
      display_ctrl_cmd <= DISP_CTRL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PHASE_HOLD:  phase_hold_us    <= cfg_data[PHASE_W-1:0];
        CFG_WAKE_WAIT:   wake_wait_us     <= cfg_data[WAKE_W-1:0];
        CFG_SETTLE_WAIT: settle_wait_us   <= cfg_data[SETTLE_W-1:0];
        CFG_POWER_UP:    power_up_wait_us <= cfg_data[PWR_W-1:0];
        CFG_FUNC_SET:    function_set_cmd <= cfg_data[CMD_W-1:0];
        CFG_DISP_CTRL:   display_ctrl_cmd <= cfg_data[CMD_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold the write item's byte and register select
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_byte <= byte_value;
      item_rs   <= register_select;
    end
  end

  // Pick the init command byte for this nibble slot
  always_comb begin
    case (cmd.nib_idx[NIB_IDX_W-1:1])
      3'd2:    init_byte = function_set_cmd;
      3'd3:    init_byte = CMD_CLEAR;
      3'd4:    init_byte = CMD_ENTRY;
      3'd5:    init_byte = display_ctrl_cmd;
      default: init_byte = '0;
    endcase
  end

  // Select the nibble and the extra wait on the enable-low phase
  always_comb begin
    extra = '0;
    if (!cmd.init) begin
      sel_nib = cmd.nib_idx[0] ? item_byte[NIB_W-1:0] : item_byte[CMD_W-1:NIB_W];
    end else if (cmd.nib_idx < NIB_FIRST_CMD) begin
      sel_nib = (cmd.nib_idx == NIB_FIRST_CMD - 1'b1) ? FOURBIT_NIB : WAKE_NIB;
      if (cmd.nib_idx == '0) extra = wake_wait_us;
      else                   extra = WAKE_W'(settle_wait_us);
    end else begin
      sel_nib = cmd.nib_idx[0] ? init_byte[NIB_W-1:0] : init_byte[CMD_W-1:NIB_W];
      if (cmd.nib_idx[0]) extra = WAKE_W'(settle_wait_us);
    end
  end

  // Add the extra wait and saturate
  always_comb begin
    hold_sum = (HOLD_W+1)'(phase_hold_us);
    if (cmd.phase == PH_EN_LOW) hold_sum = hold_sum + (HOLD_W+1)'(extra);
    hold_sel = hold_sum[HOLD_W] ? '1 : hold_sum[HOLD_W-1:0];
  end

  assign sts.slot_free = !out_valid || out_ready;

  // Output register and the nibble left on the data lines
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      driven_nibble <= '0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
      if (!cmd.power) driven_nibble <= sel_nib;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rw_pin     <= 1'b0;
      last_phase <= cmd.last;
      if (cmd.power) begin
        rs_pin      <= 1'b0;
        data_nibble <= driven_nibble;
        enable_pin  <= 1'b0;
        hold_us     <= power_up_wait_us;
      end else begin
        rs_pin      <= cmd.init ? 1'b0 : item_rs;
        data_nibble <= sel_nib;
        enable_pin  <= (cmd.phase == PH_EN_HIGH);
        hold_us     <= hold_sel;
      end
    end
  end

endmodule

// ----- hw/rtl/char_lcd_nibble_sequencer_unit.sv -----
// Top level of the character LCD 4-bit bus sequencer.
// Instantiates lcdseq_ctrl and lcdseq_dp; uses lcdseq_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one item: mode 0 runs the
//   controller init sequence, mode 1 writes byte_value with register_select.
//   Output channel (out_valid/out_ready) gives one bus phase per transfer:
//   pin levels plus hold_us; last_phase marks the final phase of an item.
//   cfg_we/cfg_index/cfg_data write the timing and init command registers;
//   write them only while the block is idle.
// Timing:
//   After the item transfer the phase sequencer leaves idle and then loads
//   the first phase into the output register; one phase follows per cycle
//   while the output is not stalled. A write item gives 6 phases and an
//   init item gives 37 phases.
//   A stall on the output holds the current phase in the output register and
//   freezes the sequencer; the next item is taken once the last phase of the
//   current item is loaded, even while it still waits on the output.
// Reset: synchronous; registers return to their defaults, the data lines
//   record returns to zero and no phase is pending.
module char_lcd_nibble_sequencer_unit
  import lcdseq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  mode,
  input  logic [CMD_W-1:0]      byte_value,
  input  logic                  register_select,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  rs_pin,
  output logic                  rw_pin,
  output logic [NIB_W-1:0]      data_nibble,
  output logic                  enable_pin,
  output logic [HOLD_W-1:0]     hold_us,
  output logic                  last_phase
);

  lcdseq_cmd_t cmd;
  lcdseq_sts_t sts;

  lcdseq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .mode     (mode),
    .sts      (sts),
    .cmd      (cmd)
  );

  lcdseq_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .byte_value      (byte_value),
    .register_select (register_select),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .rs_pin          (rs_pin),
    .rw_pin          (rw_pin),
    .data_nibble     (data_nibble),
    .enable_pin      (enable_pin),
    .hold_us         (hold_us),
    .last_phase      (last_phase)
  );

endmodule

// ----- dv/char_lcd_nibble_sequencer_unit_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for char_lcd_nibble_sequencer_unit (4-bit LCD bus phases).
// Depends on lcdseq_pkg and the RTL; a built-in bus-phase predictor checks every transfer.
module char_lcd_nibble_sequencer_unit_test;
  import lcdseq_pkg::*;

  localparam int unsigned RUN_LIMIT = 2_000_000;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned RANDOM_ROUNDS = 7;
  localparam int unsigned ITEMS_PER_ROUND = 41;

  // Item codes
  localparam logic MODE_INIT = 1'b0;
  localparam logic MODE_WRITE = 1'b1;
  localparam logic RS_CMD = 1'b0;
  localparam logic RS_DATA = 1'b1;
  // Register indexes past the end of the list
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic             mode;
    logic [CMD_W-1:0] byte_val;
    logic             rs;
  } lcd_item_t;

  typedef struct packed {
    logic              rs;
    logic              rw;
    logic [NIB_W-1:0]  nib;
    logic              en;
    logic [HOLD_W-1:0] hold;
    logic              last;
  } bus_phase_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  mode = 1'b0;
  logic [CMD_W-1:0]      byte_value = '0;
  logic                  register_select = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  rs_pin;
  logic                  rw_pin;
  logic [NIB_W-1:0]      data_nibble;
  logic                  enable_pin;
  logic [HOLD_W-1:0]     hold_us;
  logic                  last_phase;

  char_lcd_nibble_sequencer_unit dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .byte_value(byte_value), .register_select(register_select),
    .out_valid(out_valid), .out_ready(out_ready),
    .rs_pin(rs_pin), .rw_pin(rw_pin), .data_nibble(data_nibble),
    .enable_pin(enable_pin), .hold_us(hold_us), .last_phase(last_phase)
  );

  // Shadow of the timing and init command registers plus the data lines
  logic [PHASE_W-1:0]  phase_hold;
  logic [WAKE_W-1:0]   wake_wait;
  logic [SETTLE_W-1:0] settle_wait;
  logic [PWR_W-1:0]    power_up_wait;
  logic [CMD_W-1:0]    func_set_byte;
  logic [CMD_W-1:0]    disp_ctrl_byte;
  logic [NIB_W-1:0]    lines_nibble;

  lcd_item_t   items_to_send[$];
  bus_phase_t  phases_due[$];
  int unsigned items_queued = 0;
  int unsigned items_taken = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_gap = 0;
  int unsigned out_stall = 0;
  bit          idle_on = 1'b0;
  lcd_item_t   next_item;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic flag_error(input string msg);
    $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // Mostly short, sometimes medium, rarely long
  function automatic int unsigned pick_delay();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [HOLD_W-1:0] clip_hold(input int unsigned us);
    return (us > 32'hFFFF) ? 16'hFFFF : us[HOLD_W-1:0];
  endfunction

  function automatic void add_phase(input logic rs, input logic [NIB_W-1:0] nib,
                                    input logic en, input int unsigned us);
    bus_phase_t p;
    p.rs = rs;
    p.rw = 1'b0;
    p.nib = nib;
    p.en = en;
    p.hold = clip_hold(us);
    p.last = 1'b0;
    phases_due.push_back(p);
  endfunction

  // Setup, enable high, enable low; the extra wait rides on enable low
  function automatic void add_nibble(input logic rs, input logic [NIB_W-1:0] nib,
                                     input int unsigned extra);
    lines_nibble = nib;
    add_phase(rs, nib, 1'b0, 32'(phase_hold));
    add_phase(rs, nib, 1'b1, 32'(phase_hold));
    add_phase(rs, nib, 1'b0, 32'(phase_hold) + extra);
  endfunction

  function automatic void add_byte(input logic rs, input logic [CMD_W-1:0] b,
                                   input int unsigned extra);
    add_nibble(rs, b[7:4], 0);
    add_nibble(rs, b[3:0], extra);
  endfunction

  function automatic void predict_bus_phases(input logic md, input logic [CMD_W-1:0] b,
                                             input logic rs);
    bus_phase_t p;
    if (md == MODE_WRITE) begin
      add_byte(rs, b, 0);
    end else begin
      // Power-up wait keeps whatever nibble is still on the lines
      add_phase(RS_CMD, lines_nibble, 1'b0, 32'(power_up_wait));
      add_nibble(RS_CMD, WAKE_NIB, 32'(wake_wait));
      add_nibble(RS_CMD, WAKE_NIB, 32'(settle_wait));
      add_nibble(RS_CMD, WAKE_NIB, 32'(settle_wait));
      add_nibble(RS_CMD, FOURBIT_NIB, 32'(settle_wait));
      add_byte(RS_CMD, func_set_byte, 32'(settle_wait));
      add_byte(RS_CMD, CMD_CLEAR, 32'(settle_wait));
      add_byte(RS_CMD, CMD_ENTRY, 32'(settle_wait));
      add_byte(RS_CMD, disp_ctrl_byte, 32'(settle_wait));
    end
    p = phases_due.pop_back();
    p.last = 1'b1;
    phases_due.push_back(p);
  endfunction

  // Drive one register write; the caller drops cfg_we after the last one
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_PHASE_HOLD:  phase_hold = val[PHASE_W-1:0];
      CFG_WAKE_WAIT:   wake_wait = val[WAKE_W-1:0];
      CFG_SETTLE_WAIT: settle_wait = val[SETTLE_W-1:0];
      CFG_POWER_UP:    power_up_wait = val[PWR_W-1:0];
      CFG_FUNC_SET:    func_set_byte = val[CMD_W-1:0];
      CFG_DISP_CTRL:   disp_ctrl_byte = val[CMD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [15:0] ph, input logic [15:0] wk, input logic [15:0] st,
                          input logic [15:0] pw, input logic [15:0] fs, input logic [15:0] dc,
                          input bit spare);
    write_reg(CFG_PHASE_HOLD, ph);
    write_reg(CFG_WAKE_WAIT, wk);
    write_reg(CFG_SETTLE_WAIT, st);
    write_reg(CFG_POWER_UP, pw);
    write_reg(CFG_FUNC_SET, fs);
    write_reg(CFG_DISP_CTRL, dc);
    if (spare) begin
      write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO,
                16'($urandom_range(0, 65535)));
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_reg_value(input int unsigned lo, input int unsigned hi);
    case ($urandom_range(0, 3))
      0: return 16'(lo);
      1: return 16'(hi);
      2: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(lo, hi));
    endcase
  endfunction

  task automatic queue_item(input logic md, input logic [CMD_W-1:0] b, input logic rs);
    lcd_item_t it;
    it.mode = md;
    it.byte_val = b;
    it.rs = rs;
    items_to_send.push_back(it);
    items_queued++;
  endtask

  // Hold until every queued item is taken and every phase has come out
  task automatic wait_drained();
    while (!(items_taken == items_queued && phases_due.size() == 0)) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Input side: present queued items, record transfers, insert random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_bus_phases(mode, byte_value, register_select);
        items_taken++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (items_to_send.size() != 0) begin
          next_item = items_to_send.pop_front();
          in_valid <= 1'b1;
          mode <= next_item.mode;
          byte_value <= next_item.byte_val;
          register_select <= next_item.rs;
          send_gap <= (idle_on && $urandom_range(0, 2) == 0) ? pick_delay() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output side: check each transfer against the oldest expected phase
  always @(posedge clk) begin
    bus_phase_t want;
    if (rst) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (phases_due.size() == 0) begin
          flag_error($sformatf("unexpected phase nib %0h hold %0d", data_nibble, hold_us));
        end else begin
          want = phases_due.pop_front();
          if (rs_pin !== want.rs)
            flag_error($sformatf("rs_pin got %0b expected %0b", rs_pin, want.rs));
          if (rw_pin !== want.rw)
            flag_error($sformatf("rw_pin got %0b expected %0b", rw_pin, want.rw));
          if (data_nibble !== want.nib)
            flag_error($sformatf("data_nibble got %0h expected %0h", data_nibble, want.nib));
          if (enable_pin !== want.en)
            flag_error($sformatf("enable_pin got %0b expected %0b", enable_pin, want.en));
          if (hold_us !== want.hold)
            flag_error($sformatf("hold_us got %0d expected %0d", hold_us, want.hold));
          if (last_phase !== want.last)
            flag_error($sformatf("last_phase got %0b expected %0b", last_phase, want.last));
        end
      end
      if (out_stall != 0) begin
        out_ready <= 1'b0;
        out_stall <= out_stall - 1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        out_stall <= pick_delay();
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("char_lcd_nibble_sequencer_unit regression: fail");
      $finish;
    end
  end

  initial begin
    phase_hold = PHASE_HOLD_RST;
    wake_wait = WAKE_WAIT_RST;
    settle_wait = SETTLE_WAIT_RST;
    power_up_wait = POWER_UP_RST;
    func_set_byte = FUNC_SET_RST;
    disp_ctrl_byte = DISP_CTRL_RST;
    lines_nibble = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset defaults: init right out of reset shows the zeroed data lines,
    // ignored fields set, then byte extremes and inits that inherit the lines
    queue_item(MODE_INIT, 8'hFF, RS_DATA);
    queue_item(MODE_WRITE, 8'h00, RS_CMD);
    queue_item(MODE_WRITE, 8'hFF, RS_DATA);
    queue_item(MODE_WRITE, 8'hA5, RS_CMD);
    queue_item(MODE_WRITE, 8'h5A, RS_DATA);
    queue_item(MODE_INIT, 8'h00, RS_CMD);
    queue_item(MODE_INIT, 8'h81, RS_DATA);
    wait_drained();

    // Top of range with masking, wake wait saturating the hold, spare index ignored
    set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h00FF, 1'b1);
    queue_item(MODE_INIT, 8'h3C, RS_DATA);
    queue_item(MODE_WRITE, 8'h3C, RS_DATA);
    wait_drained();

    // Bottom of range: zero waits and zero command bytes
    set_regs(16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
    queue_item(MODE_WRITE, 8'h81, RS_CMD);
    queue_item(MODE_INIT, 8'h7E, RS_CMD);
    queue_item(MODE_WRITE, 8'h7E, RS_DATA);
    wait_drained();

    // Documented upper bounds, cursor-on display control
    set_regs(16'd5000, 16'd50000, 16'd5000, 16'd15000, 16'h0028, 16'h000F, 1'b0);
    queue_item(MODE_INIT, 8'h55, RS_DATA);
    queue_item(MODE_WRITE, 8'hC3, RS_DATA);
    queue_item(MODE_INIT, 8'hAA, RS_CMD);
    wait_drained();

    // Random rounds: fresh register set, mostly byte writes, some inits
    for (int unsigned round = 0; round < RANDOM_ROUNDS; round++) begin
      idle_on = (round == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
      set_regs(pick_reg_value(1, 5000), pick_reg_value(0, 50000), pick_reg_value(0, 5000),
               pick_reg_value(0, 65535), pick_reg_value(0, 255), pick_reg_value(0, 255),
               1'($urandom_range(0, 1)));
      for (int unsigned n = 0; n < ITEMS_PER_ROUND; n++) begin
        if ($urandom_range(0, 99) < 12)
          queue_item(MODE_INIT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        else
          queue_item(MODE_WRITE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("char_lcd_nibble_sequencer_unit regression: pass");
    end else begin
      $display("char_lcd_nibble_sequencer_unit regression: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/lcdseq_pkg.sv
hw/rtl/lcdseq_ctrl.sv
hw/rtl/lcdseq_dp.sv
hw/rtl/char_lcd_nibble_sequencer_unit.sv
dv/char_lcd_nibble_sequencer_unit_test.sv
